// File: rtl/smooth_l1_loss_defines.svh
// Assertion helpers shared by the RTL of the smooth L1 loss block.
`ifndef SMOOTH_L1_LOSS_DEFINES_SVH
`define SMOOTH_L1_LOSS_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SL1_ASSERT_IMP(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("smooth_l1_loss: check failed");

// The consequent must hold a fixed number of cycles after the antecedent.
`define SL1_ASSERT_DLY(name, ante, n, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##n (cons)) \
		else $error("smooth_l1_loss: delayed check failed");

`endif

// File: rtl/sl1_pkg.sv
package sl1_pkg;

	localparam int DATA_W    = 32;
	localparam int BETA_W    = 31;
	localparam int DIFF_W    = 33;
	localparam int SQ_W      = 62;
	localparam int QUO_W     = 30;
	localparam int DVS_W     = 32;
	localparam int U_W       = 33;
	localparam int Q_FRAC    = 16;
	localparam int PP_LO_W   = Q_FRAC + DATA_W;
	localparam int PP_HI_W   = (U_W - Q_FRAC) + DATA_W;
	localparam int MAG_W     = PP_HI_W;
	localparam int CFG_IDX_W = 1;
	localparam int LATENCY   = 3 + QUO_W + 3;

	localparam logic [CFG_IDX_W-1:0] REG_BETA  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'b1;

	localparam logic [BETA_W-1:0] BETA_RESET      = 31'd65536;
	localparam logic [BETA_W-1:0] HALF_BETA_RESET = 31'd32768;
	localparam logic [DATA_W-1:0] SMAG_RESET      = 32'd65536;

	localparam logic [DATA_W-1:0] POS_LIMIT = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] NEG_LIMIT = 32'h8000_0000;

	typedef struct packed {
		logic [SQ_W-1:0] w;
		logic            quad;
		logic [U_W-1:0]  ulin;
		logic            last;
	} div_stage_t;

endpackage

// File: rtl/smooth_l1_loss.sv
// Channel   Handshake                    Payload
// input     start, busy                  prediction, label, is_last
// result    done (one-cycle strobe)      loss, saturated, last_out
// config    cfg_valid, cfg_ready         cfg_index, cfg_data
//
// One item is accepted per cycle; busy is never raised.
// Each result passes in order through three front stages,
// a 30-stage restoring divider with one quotient bit per stage, and three
// stages for scaling and saturation.
// The receiver cannot stall, so the pipeline never holds; reset clears all
// valid bits and loads beta and scale with 1.0.
`include "smooth_l1_loss_defines.svh"

module smooth_l1_loss (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic signed [sl1_pkg::DATA_W-1:0]   prediction,
	input  logic signed [sl1_pkg::DATA_W-1:0]   label,
	input  logic                                is_last,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [sl1_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [sl1_pkg::DATA_W-1:0]          cfg_data,
	output logic                                done,
	output logic signed [sl1_pkg::DATA_W-1:0]   loss,
	output logic                                saturated,
	output logic                                last_out
);
	import sl1_pkg::*;

	logic [BETA_W-1:0] beta_q;
	logic [BETA_W-1:0] half_beta_q;
	logic [DATA_W-1:0] smag_q;
	logic              sneg_q;
	logic [BETA_W-1:0] cfg_half;
	logic [DATA_W-1:0] cfg_smag;
	logic [DVS_W-1:0]  dvs;

	logic              v_s1;
	logic [DIFF_W-1:0] diff_s1;
	logic              last_s1;
	logic              v_s2;
	logic [DIFF_W-1:0] d_s2;
	logic              last_s2;
	logic              v_s3;
	logic [SQ_W-1:0]   sq_s3;
	logic              quad_s3;
	logic [U_W-1:0]    ulin_s3;
	logic              last_s3;
	logic [SQ_W-1:0]   sq_c;

	logic       div_v_s [0:QUO_W];
	div_stage_t div_s   [0:QUO_W];

	logic [U_W-1:0]     u_c;
	logic               v_s34;
	logic [PP_LO_W-1:0] pp_lo_s34;
	logic [PP_HI_W-1:0] pp_hi_s34;
	logic               last_s34;
	logic               v_s35;
	logic [MAG_W-1:0]   mag_s35;
	logic               last_s35;
	logic               accept;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept    = start & ~busy;

	assign cfg_half = BETA_W'(({1'b0, cfg_data[BETA_W-1:0]} + 32'd1) >> 1);
	assign cfg_smag = cfg_data[DATA_W-1] ? (~cfg_data + 32'd1) : cfg_data;
	assign dvs      = {beta_q, 1'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			beta_q      <= BETA_RESET;
			half_beta_q <= HALF_BETA_RESET;
			smag_q      <= SMAG_RESET;
			sneg_q      <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_BETA: begin
					beta_q      <= cfg_data[BETA_W-1:0];
					half_beta_q <= cfg_half;
				end
				REG_SCALE: begin
					smag_q <= cfg_smag;
					sneg_q <= cfg_data[DATA_W-1];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0;
			v_s2  <= 1'b0;
			v_s3  <= 1'b0;
			v_s34 <= 1'b0;
			v_s35 <= 1'b0;
			done  <= 1'b0;
		end else begin
			v_s1  <= accept;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s34 <= div_v_s[QUO_W];
			v_s35 <= v_s34;
			done  <= v_s35;
		end
	end

	assign sq_c = d_s2[BETA_W-1:0] * d_s2[BETA_W-1:0];

	always_ff @(posedge clk) begin
		diff_s1 <= {prediction[DATA_W-1], prediction} - {label[DATA_W-1], label};
		last_s1 <= is_last;
		d_s2    <= diff_s1[DIFF_W-1] ? (~diff_s1 + 33'd1) : diff_s1;
		last_s2 <= last_s1;
		sq_s3   <= sq_c;
		quad_s3 <= (beta_q != '0) && (d_s2 < {2'b00, beta_q});
		ulin_s3 <= d_s2 - {2'b00, half_beta_q};
		last_s3 <= last_s2;
	end

	assign div_v_s[0] = v_s3;
	assign div_s[0]   = '{w: sq_s3, quad: quad_s3, ulin: ulin_s3, last: last_s3};

	for (genvar k = 0; k < QUO_W; k++) begin : g_div
		logic [DVS_W:0]   trial;
		logic             ge;
		logic [DVS_W-1:0] nrem;

		assign trial = {div_s[k].w[SQ_W-1:QUO_W], div_s[k].w[QUO_W-1]};
		assign ge    = trial >= {1'b0, dvs};
		assign nrem  = ge ? DVS_W'(trial - {1'b0, dvs}) : trial[DVS_W-1:0];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				div_v_s[k+1] <= 1'b0;
			end else begin
				div_v_s[k+1] <= div_v_s[k];
			end
		end

		always_ff @(posedge clk) begin
			div_s[k+1].w    <= {nrem, div_s[k].w[QUO_W-2:0], ge};
			div_s[k+1].quad <= div_s[k].quad;
			div_s[k+1].ulin <= div_s[k].ulin;
			div_s[k+1].last <= div_s[k].last;
		end
	end

	assign u_c = div_s[QUO_W].quad ? {3'b000, div_s[QUO_W].w[QUO_W-1:0]} : div_s[QUO_W].ulin;

	always_ff @(posedge clk) begin
		pp_lo_s34 <= u_c[Q_FRAC-1:0] * smag_q;
		pp_hi_s34 <= u_c[U_W-1:Q_FRAC] * smag_q;
		last_s34  <= div_s[QUO_W].last;
		mag_s35   <= pp_hi_s34 + MAG_W'(pp_lo_s34 >> Q_FRAC);
		last_s35  <= last_s34;
		last_out  <= last_s35;
		if (sneg_q) begin
			if (mag_s35 > MAG_W'(NEG_LIMIT)) begin
				loss      <= NEG_LIMIT;
				saturated <= 1'b1;
			end else begin
				loss      <= ~mag_s35[DATA_W-1:0] + 32'd1;
				saturated <= 1'b0;
			end
		end else begin
			if (mag_s35 > MAG_W'(POS_LIMIT)) begin
				loss      <= POS_LIMIT;
				saturated <= 1'b1;
			end else begin
				loss      <= mag_s35[DATA_W-1:0];
				saturated <= 1'b0;
			end
		end
	end

	`SL1_ASSERT_DLY(a_latency, accept, 36, done)
	`SL1_ASSERT_IMP(a_sign, done, (loss[DATA_W-1] == sneg_q) || (loss == '0))
	`SL1_ASSERT_IMP(a_clip, done && saturated, (loss == POS_LIMIT) || (loss == NEG_LIMIT))
	`SL1_ASSERT_DLY(a_div_flow, v_s3, 33, done)

endmodule

// File: tb/testbench.sv
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import sl1_pkg::*;

	localparam logic [DATA_W-1:0] MAX_Q = 32'h7FFF_FFFF;
	localparam logic [DATA_W-1:0] MIN_Q = 32'h8000_0000;
	localparam logic [DATA_W-1:0] ONE_Q = 32'h0001_0000;
	localparam int CYCLE_LIMIT = 200000;
	localparam int PRINT_LIMIT = 100;

	typedef enum logic [1:0] {OP_ITEM, OP_CFG, OP_DRAIN} op_kind_e;

	typedef struct packed {
		op_kind_e               kind;
		logic [DATA_W-1:0]      pred;
		logic [DATA_W-1:0]      lab;
		logic                   last;
		logic [CFG_IDX_W-1:0]   idx;
		logic [DATA_W-1:0]      data;
		int                     idle_pct;
	} pend_op_t;

	typedef struct packed {
		logic [DATA_W-1:0] loss;
		logic              sat;
		logic              last;
	} loss_rec_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        start = 1'b0;
	logic                        busy;
	logic signed [DATA_W-1:0]    prediction = '0;
	logic signed [DATA_W-1:0]    label = '0;
	logic                        is_last = 1'b0;
	logic                        cfg_valid = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index = '0;
	logic [DATA_W-1:0]           cfg_data = '0;
	logic                        done;
	logic signed [DATA_W-1:0]    loss;
	logic                        saturated;
	logic                        last_out;

	pend_op_t  pending_ops[$];
	loss_rec_t expected_losses[$];

	logic [BETA_W-1:0]        model_beta = BETA_RESET;
	logic signed [DATA_W-1:0] model_scale = ONE_Q;
	logic [BETA_W-1:0]        gen_beta = BETA_RESET;
	int                       cur_idle = 0;
	int                       mismatches = 0;
	int                       cycle_count = 0;

	smooth_l1_loss dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.prediction (prediction),
		.label      (label),
		.is_last    (is_last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.done       (done),
		.loss       (loss),
		.saturated  (saturated),
		.last_out   (last_out)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic loss_rec_t smooth_l1_of(logic [DATA_W-1:0] p, logic [DATA_W-1:0] l,
			logic lst);
		longint     diff;
		longint     sl;
		logic [63:0] d;
		logic [63:0] b;
		logic [63:0] u;
		logic [63:0] smag;
		logic [63:0] mag;
		loss_rec_t  r;
		diff = longint'($signed(p)) - longint'($signed(l));
		d = (diff < 0) ? -diff : diff;
		b = 64'(model_beta);
		sl = longint'(model_scale);
		smag = (sl < 0) ? -sl : sl;
		if (b != 0 && d < b)
			u = (d * d) / (64'd2 * b);
		else
			u = (64'd2 * d - b) >> 1;
		mag = (u * smag) >> Q_FRAC;
		r.sat = 1'b0;
		if (sl < 0) begin
			if (mag > 64'(NEG_LIMIT)) begin
				mag = 64'(NEG_LIMIT);
				r.sat = 1'b1;
			end
			mag = 64'd0 - mag;
		end else if (mag > 64'(POS_LIMIT)) begin
			mag = 64'(POS_LIMIT);
			r.sat = 1'b1;
		end
		r.loss = mag[DATA_W-1:0];
		r.last = lst;
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < PRINT_LIMIT)
			$display("MISMATCH at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic add_item(logic [DATA_W-1:0] p, logic [DATA_W-1:0] l, logic lst);
		pend_op_t op;
		op = '0;
		op.kind = OP_ITEM;
		op.pred = p;
		op.lab = l;
		op.last = lst;
		op.idle_pct = cur_idle;
		pending_ops.push_back(op);
	endtask

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [DATA_W-1:0] data);
		pend_op_t op;
		op = '0;
		op.kind = OP_CFG;
		op.idx = idx;
		op.data = data;
		pending_ops.push_back(op);
		if (idx == REG_BETA)
			gen_beta = data[BETA_W-1:0];
	endtask

	task automatic add_drain();
		pend_op_t op;
		op = '0;
		op.kind = OP_DRAIN;
		pending_ops.push_back(op);
	endtask

	function automatic logic [DATA_W-1:0] corner_value();
		case ($urandom_range(0, 5))
			0: return MIN_Q;
			1: return MAX_Q;
			2: return '0;
			3: return '1;
			4: return {1'b0, gen_beta};
			default: return $urandom_range(0, 3);
		endcase
	endfunction

	always @(posedge clk) begin : drive_items
		pend_op_t              op;
		logic                  nx_start;
		logic                  nx_cfg;
		logic [DATA_W-1:0]     nx_pred;
		logic [DATA_W-1:0]     nx_lab;
		logic                  nx_last;
		logic [CFG_IDX_W-1:0]  nx_idx;
		logic [DATA_W-1:0]     nx_data;
		if (!arst_n) begin
			start <= 1'b0;
			cfg_valid <= 1'b0;
		end else begin
			if (start && !busy)
				expected_losses.push_back(smooth_l1_of(prediction, label, is_last));
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_BETA)
					model_beta = cfg_data[BETA_W-1:0];
				else if (cfg_index == REG_SCALE)
					model_scale = cfg_data;
			end
			nx_start = start && busy;
			nx_cfg = cfg_valid && !cfg_ready;
			nx_pred = prediction;
			nx_lab = label;
			nx_last = is_last;
			nx_idx = cfg_index;
			nx_data = cfg_data;
			if (!nx_start && !nx_cfg && pending_ops.size() > 0) begin
				op = pending_ops[0];
				case (op.kind)
					OP_ITEM: begin
						if ($urandom_range(0, 99) >= op.idle_pct) begin
							op = pending_ops.pop_front();
							nx_start = 1'b1;
							nx_pred = op.pred;
							nx_lab = op.lab;
							nx_last = op.last;
						end
					end
					OP_CFG: begin
						if (expected_losses.size() == 0) begin
							op = pending_ops.pop_front();
							nx_cfg = 1'b1;
							nx_idx = op.idx;
							nx_data = op.data;
						end
					end
					default: begin
						if (expected_losses.size() == 0)
							op = pending_ops.pop_front();
					end
				endcase
			end
			start <= nx_start;
			cfg_valid <= nx_cfg;
			prediction <= nx_pred;
			label <= nx_lab;
			is_last <= nx_last;
			cfg_index <= nx_idx;
			cfg_data <= nx_data;
		end
	end

	always @(negedge clk) begin : check_results
		loss_rec_t want;
		if (arst_n && done) begin
			if (expected_losses.size() == 0) begin
				report_mismatch($sformatf("result with none expected, loss=%h", loss));
			end else begin
				want = expected_losses.pop_front();
				if (loss !== want.loss)
					report_mismatch($sformatf("loss %h, expected %h", loss, want.loss));
				if (saturated !== want.sat)
					report_mismatch($sformatf("saturated %b, expected %b", saturated,
						want.sat));
				if (last_out !== want.last)
					report_mismatch($sformatf("last_out %b, expected %b", last_out,
						want.last));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin : run_test
		int                idle_pcts[3];
		int                mode;
		logic [DATA_W-1:0] lab;
		logic [DATA_W-1:0] pred;
		logic [DATA_W:0]   span;
		logic [DATA_W:0]   dist_mag;
		idle_pcts[0] = 0;
		idle_pcts[1] = 52;
		idle_pcts[2] = 9;

		cur_idle = 0;
		add_item('0, '0, 1'b0);
		add_item(MAX_Q, MIN_Q, 1'b1);
		add_item(MIN_Q, MAX_Q, 1'b0);
		add_item(MIN_Q, MIN_Q, 1'b0);
		add_item(32'h0000_8000, '0, 1'b0);
		add_item(32'h0000_FFFF, '0, 1'b1);
		add_item(32'h0001_0000, '0, 1'b0);
		add_item('0, 32'h0001_0001, 1'b0);
		add_item(32'hFFFF_0000, 32'h0002_0000, 1'b1);
		add_cfg(REG_BETA, '0);
		add_item(MAX_Q, MIN_Q, 1'b0);
		add_item(32'd5, 32'hFFFF_FFFD, 1'b1);
		add_cfg(REG_BETA, {1'b0, MAX_Q[BETA_W-1:0]});
		add_cfg(REG_SCALE, MAX_Q);
		add_item(MAX_Q, MIN_Q, 1'b0);
		add_item(32'h4000_0000, '0, 1'b0);
		add_item(32'h7FFF_FFFE, '0, 1'b1);
		add_cfg(REG_SCALE, MIN_Q);
		add_item(MAX_Q, MIN_Q, 1'b0);
		add_item(32'd1, '0, 1'b1);
		add_cfg(REG_SCALE, '0);
		add_item(MAX_Q, MIN_Q, 1'b0);
		add_cfg(REG_BETA, ONE_Q);
		add_cfg(REG_SCALE, 32'hFFFF_0000);
		add_item(32'd100000, 32'hFFFF_FFFD, 1'b1);
		add_item(32'h0000_4000, '0, 1'b0);

		for (int ph = 0; ph < 6; ph++) begin
			cur_idle = idle_pcts[ph % 3];
			case ($urandom_range(0, 4))
				0: add_cfg(REG_BETA, '0);
				1: add_cfg(REG_BETA, {1'b0, MAX_Q[BETA_W-1:0]});
				2: add_cfg(REG_BETA, $urandom_range(0, 32'h0004_0000));
				default: add_cfg(REG_BETA, {1'b0, BETA_W'($urandom() >> 1)});
			endcase
			case ($urandom_range(0, 5))
				0: add_cfg(REG_SCALE, MIN_Q);
				1: add_cfg(REG_SCALE, MAX_Q);
				2: add_cfg(REG_SCALE, ONE_Q);
				3: add_cfg(REG_SCALE, 32'hFFFF_0000);
				4: add_cfg(REG_SCALE, $urandom_range(0, 32'h0004_0000));
				default: add_cfg(REG_SCALE, $urandom());
			endcase
			for (int n = 0; n < 250; n++) begin
				if ($urandom_range(0, 99) == 0 || n == 125)
					add_drain();
				mode = $urandom_range(0, 9);
				lab = $urandom();
				if (mode < 3) begin
					pred = $urandom();
				end else if (mode < 8) begin
					span = (gen_beta == 0) ? 33'd4096 : {2'b00, gen_beta};
					dist_mag = {1'b0, $urandom_range(0, span[DATA_W-1:0])};
					if ($urandom_range(0, 1))
						dist_mag = dist_mag + span;
					pred = $urandom_range(0, 1) ? lab + dist_mag[DATA_W-1:0]
						: lab - dist_mag[DATA_W-1:0];
				end else begin
					pred = corner_value();
					lab = corner_value();
				end
				add_item(pred, lab, $urandom_range(0, 7) == 0);
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_ops.size() != 0 || start || cfg_valid || expected_losses.size() != 0)
			@(posedge clk);
		repeat (LATENCY + 8) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

// File: sim.f
+incdir+rtl
rtl/sl1_pkg.sv
rtl/smooth_l1_loss.sv
tb/testbench.sv
